[hdl/lzwd_pkg.sv]
// Shared constants and types of the LZW decoder.
// Used by every module of the block; depends on nothing.
package lzwd_pkg;

   localparam int CODE_W      = 12;
   localparam int DICT_DEPTH  = 4096;
   localparam int LIT_COUNT   = 256;
   localparam int END_CODE    = DICT_DEPTH - 2;
   localparam int MAX_STRING  = 256;
   localparam int LEN_W       = 8;
   localparam int STORE_W     = 20;
   localparam int HELD_W      = 5;
   localparam int WIDTH_W     = 4;
   localparam int NEXT_W      = 13;
   localparam int MIN_WIDTH   = 9;
   localparam int MAX_WIDTH   = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] STATUS_DATA = 2'd0;
   localparam logic [1:0] STATUS_END  = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   typedef logic [CODE_W-1:0] code_type;

   typedef enum logic [2:0] {
      KIND_FIRST,
      KIND_BAD,
      KIND_END,
      KIND_KNOWN,
      KIND_KWKWK
   } kind_type;

   // One classified code handed from the front end to the expander.
   typedef struct packed {
      code_type code;
      kind_type kind;
      logic     add;
      code_type new_code;
   } cmd_type;

   typedef struct packed {
      code_type         prefix;
      logic [7:0]       last_byte;
      logic [7:0]       first_byte;
      logic [LEN_W-1:0] length;
   } entry_type;

endpackage

[hdl/lzwd_channels.sv]
// Valid/ready channel interfaces of the LZW decoder.
// Depends on nothing.
interface lzwd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       stream_end;
   modport source (output valid, in_byte, stream_end, input ready);
   modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface lzwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte0;
   logic [7:0] out_byte1;
   logic [7:0] out_byte2;
   logic [7:0] out_byte3;
   logic [2:0] byte_count;
   logic       last_of_code;
   logic [1:0] status;
   modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3,
                   byte_count, last_of_code, status, input ready);
   modport sink   (input valid, out_byte0, out_byte1, out_byte2, out_byte3,
                   byte_count, last_of_code, status, output ready);
endinterface

[hdl/lzwd_front.sv]
// Front end: unpacks compressed bytes into codes and classifies them.
// Depends on lzwd_pkg and lzwd_channels.
module lzwd_front (
   input  logic              clock,
   input  logic              reset,
   lzwd_req_if.sink          req_if,
   output logic              cmd_valid,
   output lzwd_pkg::cmd_type cmd_data,
   input  logic              cmd_ready
);

   typedef enum logic [1:0] {PH_FIRST, PH_DECODE, PH_STOPPED} phase_type;

   phase_type                         phase_ff, phase_in;
   logic [lzwd_pkg::STORE_W-1:0]      bit_store_ff, bit_store_in;
   logic [lzwd_pkg::HELD_W-1:0]       bits_held_ff, bits_held_in;
   logic [lzwd_pkg::WIDTH_W-1:0]      code_width_ff, code_width_in;
   logic [lzwd_pkg::NEXT_W-1:0]       next_free_ff, next_free_in;

   logic                              accept;
   logic                              have_code;
   logic [lzwd_pkg::STORE_W-1:0]      store_cat, shifted, rest_mask;
   logic [lzwd_pkg::HELD_W-1:0]       held_sum, shift_amt;
   logic [lzwd_pkg::NEXT_W-1:0]       code_mask, nf_plus;
   lzwd_pkg::code_type                code_val;

   assign req_if.ready = cmd_ready;
   assign accept       = req_if.valid && cmd_ready;

   always_comb begin
      store_cat = {bit_store_ff[lzwd_pkg::STORE_W-9:0], req_if.in_byte};
      held_sum  = bits_held_ff + lzwd_pkg::HELD_W'(8);
      have_code = (phase_ff != PH_STOPPED) &&
                  (held_sum >= lzwd_pkg::HELD_W'(code_width_ff));
      shift_amt = held_sum - lzwd_pkg::HELD_W'(code_width_ff);
      shifted   = store_cat >> shift_amt;
      code_mask = (lzwd_pkg::NEXT_W'(1) << code_width_ff) - lzwd_pkg::NEXT_W'(1);
      code_val  = shifted[lzwd_pkg::CODE_W-1:0] & code_mask[lzwd_pkg::CODE_W-1:0];
      rest_mask = (lzwd_pkg::STORE_W'(1) << shift_amt) - lzwd_pkg::STORE_W'(1);
      nf_plus   = next_free_ff + lzwd_pkg::NEXT_W'(1);

      phase_in      = phase_ff;
      bit_store_in  = bit_store_ff;
      bits_held_in  = bits_held_ff;
      code_width_in = code_width_ff;
      next_free_in  = next_free_ff;

      cmd_valid         = 1'b0;
      cmd_data.code     = code_val;
      cmd_data.kind     = lzwd_pkg::KIND_KNOWN;
      cmd_data.add      = next_free_ff < lzwd_pkg::NEXT_W'(lzwd_pkg::DICT_DEPTH);
      cmd_data.new_code = next_free_ff[lzwd_pkg::CODE_W-1:0];

      if (accept) begin
         if (phase_ff != PH_STOPPED) begin
            bit_store_in = have_code ? (store_cat & rest_mask) : store_cat;
            bits_held_in = have_code ? shift_amt : held_sum;
         end
         if (have_code) begin
            cmd_valid = 1'b1;
            case (phase_ff)
               PH_FIRST: begin
                  if (code_val >= lzwd_pkg::CODE_W'(lzwd_pkg::LIT_COUNT)) begin
                     cmd_data.kind = lzwd_pkg::KIND_BAD;
                     phase_in      = PH_STOPPED;
                  end else begin
                     cmd_data.kind = lzwd_pkg::KIND_FIRST;
                     phase_in      = PH_DECODE;
                  end
               end
               default: begin
                  if (code_val == lzwd_pkg::CODE_W'(lzwd_pkg::END_CODE)) begin
                     cmd_data.kind = lzwd_pkg::KIND_END;
                     phase_in      = PH_STOPPED;
                  end else begin
                     if (lzwd_pkg::NEXT_W'(code_val) < next_free_ff) begin
                        cmd_data.kind = lzwd_pkg::KIND_KNOWN;
                     end else begin
                        cmd_data.kind = lzwd_pkg::KIND_KWKWK;
                     end
                     // grow the code width as the dictionary fills
                     if (cmd_data.add) begin
                        next_free_in = nf_plus;
                        if ((nf_plus >= (lzwd_pkg::NEXT_W'(1) << code_width_ff)) &&
                            (code_width_ff < lzwd_pkg::WIDTH_W'(lzwd_pkg::MAX_WIDTH))) begin
                           code_width_in = code_width_ff + lzwd_pkg::WIDTH_W'(1);
                        end
                     end
                  end
               end
            endcase
         end
         if (req_if.stream_end) begin
            phase_in      = PH_FIRST;
            bit_store_in  = '0;
            bits_held_in  = '0;
            code_width_in = lzwd_pkg::WIDTH_W'(lzwd_pkg::MIN_WIDTH);
            next_free_in  = lzwd_pkg::NEXT_W'(lzwd_pkg::LIT_COUNT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         bit_store_ff  <= '0;
         bits_held_ff  <= '0;
         code_width_ff <= lzwd_pkg::WIDTH_W'(lzwd_pkg::MIN_WIDTH);
         next_free_ff  <= lzwd_pkg::NEXT_W'(lzwd_pkg::LIT_COUNT);
      end else begin
         phase_ff      <= phase_in;
         bit_store_ff  <= bit_store_in;
         bits_held_ff  <= bits_held_in;
         code_width_ff <= code_width_in;
         next_free_ff  <= next_free_in;
      end
   end

endmodule

[hdl/lzwd_code_fifo.sv]
// Two-entry queue of classified codes between front end and expander.
// Depends on lzwd_pkg.
module lzwd_code_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lzwd_pkg::cmd_type push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output lzwd_pkg::cmd_type pop_data,
   input  logic              pop_ready
);

   lzwd_pkg::cmd_type slots [lzwd_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'(lzwd_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/lzwd_back.sv]
// Expander: walks dictionary chains into a reverse stack and sends the
// string out up to four bytes to a result. Depends on lzwd_pkg and lzwd_channels.
module lzwd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lzwd_pkg::cmd_type cmd_data,
   output logic              cmd_ready,
   lzwd_rsp_if.source        rsp_if
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_WALK, ST_LIT, ST_GATHER, ST_PUSH, ST_FLAG
   } state_type;

   localparam logic [lzwd_pkg::LEN_W-1:0] MAX_LEN = lzwd_pkg::LEN_W'(lzwd_pkg::MAX_STRING - 1);

   lzwd_pkg::entry_type dict_mem  [lzwd_pkg::DICT_DEPTH];
   logic [7:0]          stack_mem [lzwd_pkg::MAX_STRING];
   lzwd_pkg::entry_type dict_q_ff;
   logic [7:0]          stack_q_ff;

   state_type                  state_ff, state_in;
   lzwd_pkg::cmd_type          cmd_ff, cmd_in;
   lzwd_pkg::code_type         cur_ff, cur_in;
   logic [lzwd_pkg::LEN_W-1:0] k_ff, k_in;
   logic [lzwd_pkg::LEN_W-1:0] total_ff, total_in;
   logic [lzwd_pkg::LEN_W-1:0] base_ff, base_in;
   logic [2:0]                 iss_ff, iss_in;
   logic [2:0]                 cap_ff, cap_in;
   logic                       pend_ff, pend_in;
   logic [7:0]                 asm_ff [4];
   logic [7:0]                 asm_in [4];
   lzwd_pkg::code_type         prev_code_ff, prev_code_in;
   logic [7:0]                 prev_first_ff, prev_first_in;
   lzwd_pkg::entry_type        prev_ent_ff, prev_ent_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_byte_ff [4];
   logic [7:0]                 rsp_byte_in [4];
   logic [2:0]                 rsp_count_ff, rsp_count_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;

   logic                       dict_rd_en, dict_wr_en;
   lzwd_pkg::code_type         dict_rd_addr, dict_wr_addr;
   lzwd_pkg::entry_type        dict_wr_data;
   logic                       stk_rd_en, stk_wr_en;
   logic [7:0]                 stk_rd_addr, stk_wr_addr, stk_wr_data;

   logic                       out_free;
   logic [lzwd_pkg::LEN_W-1:0] remain, walk_len;
   logic [2:0]                 grp;
   logic [lzwd_pkg::LEN_W:0]   base_next;
   lzwd_pkg::entry_type        lit_ent;

   // Entry for previous string plus byte f; a full-length prefix is copied.
   function automatic lzwd_pkg::entry_type make_entry(
      input lzwd_pkg::entry_type pe,
      input lzwd_pkg::code_type  pc,
      input logic [7:0]          pf,
      input logic [7:0]          f
   );
      lzwd_pkg::entry_type r;
      if (pe.length >= MAX_LEN) begin
         r        = pe;
         r.length = MAX_LEN;
      end else begin
         r.prefix     = pc;
         r.last_byte  = f;
         r.first_byte = pf;
         r.length     = pe.length + lzwd_pkg::LEN_W'(1);
      end
      return r;
   endfunction

   function automatic logic is_literal(input lzwd_pkg::code_type c);
      return c < lzwd_pkg::CODE_W'(lzwd_pkg::LIT_COUNT);
   endfunction

   assign cmd_ready           = state_ff == ST_IDLE;
   assign out_free            = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_byte0    = rsp_byte_ff[0];
   assign rsp_if.out_byte1    = rsp_byte_ff[1];
   assign rsp_if.out_byte2    = rsp_byte_ff[2];
   assign rsp_if.out_byte3    = rsp_byte_ff[3];
   assign rsp_if.byte_count   = rsp_count_ff;
   assign rsp_if.last_of_code = rsp_last_ff;
   assign rsp_if.status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      total_in      = total_ff;
      base_in       = base_ff;
      iss_in        = iss_ff;
      cap_in        = cap_ff;
      pend_in       = pend_ff;
      asm_in        = asm_ff;
      prev_code_in  = prev_code_ff;
      prev_first_in = prev_first_ff;
      prev_ent_in   = prev_ent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      dict_rd_en   = 1'b0;
      dict_rd_addr = cmd_data.code;
      dict_wr_en   = 1'b0;
      dict_wr_addr = cmd_data.new_code;
      dict_wr_data = make_entry(prev_ent_ff, prev_code_ff, prev_first_ff,
                                cmd_data.code[7:0]);
      stk_rd_en    = 1'b0;
      stk_rd_addr  = base_ff + lzwd_pkg::LEN_W'(iss_ff);
      stk_wr_en    = 1'b0;
      stk_wr_addr  = k_ff - lzwd_pkg::LEN_W'(1);
      stk_wr_data  = dict_q_ff.last_byte;

      lit_ent            = '0;
      lit_ent.length     = lzwd_pkg::LEN_W'(1);
      walk_len           = (dict_q_ff.length == '0) ? lzwd_pkg::LEN_W'(1) : dict_q_ff.length;
      remain             = total_ff - base_ff;
      grp                = (remain >= lzwd_pkg::LEN_W'(4)) ? 3'd4 : remain[2:0];
      base_next          = {1'b0, base_ff} + (lzwd_pkg::LEN_W + 1)'(grp);

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in  = cmd_data;
               base_in = '0;
               iss_in  = '0;
               cap_in  = '0;
               pend_in = 1'b0;
               asm_in  = '{default: 8'd0};
               case (cmd_data.kind)
                  lzwd_pkg::KIND_BAD, lzwd_pkg::KIND_END: begin
                     state_in = ST_FLAG;
                  end
                  lzwd_pkg::KIND_FIRST: begin
                     stk_wr_en     = 1'b1;
                     stk_wr_addr   = 8'd0;
                     stk_wr_data   = cmd_data.code[7:0];
                     total_in      = lzwd_pkg::LEN_W'(1);
                     prev_code_in  = cmd_data.code;
                     prev_first_in = cmd_data.code[7:0];
                     prev_ent_in   = lit_ent;
                     state_in      = ST_GATHER;
                  end
                  lzwd_pkg::KIND_KWKWK: begin
                     total_in = (prev_ent_ff.length < MAX_LEN) ?
                                prev_ent_ff.length + lzwd_pkg::LEN_W'(1) : prev_ent_ff.length;
                     // append the previous first byte behind the string
                     if (prev_ent_ff.length < MAX_LEN) begin
                        stk_wr_en   = 1'b1;
                        stk_wr_addr = prev_ent_ff.length;
                        stk_wr_data = prev_first_ff;
                     end
                     dict_wr_data = make_entry(prev_ent_ff, prev_code_ff, prev_first_ff,
                                               prev_first_ff);
                     if (cmd_data.add) begin
                        dict_wr_en   = 1'b1;
                        prev_code_in = cmd_data.new_code;
                        prev_ent_in  = dict_wr_data;
                     end
                     cur_in = prev_code_ff;
                     if (is_literal(prev_code_ff)) begin
                        k_in     = lzwd_pkg::LEN_W'(1);
                        state_in = ST_LIT;
                     end else begin
                        k_in         = prev_ent_ff.length;
                        dict_rd_en   = 1'b1;
                        dict_rd_addr = prev_code_ff;
                        state_in     = ST_WALK;
                     end
                  end
                  default: begin
                     if (is_literal(cmd_data.code)) begin
                        stk_wr_en     = 1'b1;
                        stk_wr_addr   = 8'd0;
                        stk_wr_data   = cmd_data.code[7:0];
                        total_in      = lzwd_pkg::LEN_W'(1);
                        dict_wr_en    = cmd_data.add;
                        prev_code_in  = cmd_data.code;
                        prev_first_in = cmd_data.code[7:0];
                        prev_ent_in   = lit_ent;
                        state_in      = ST_GATHER;
                     end else begin
                        dict_rd_en = 1'b1;
                        state_in   = ST_START;
                     end
                  end
               endcase
            end
         end
         ST_START: begin
            total_in      = walk_len;
            k_in          = walk_len;
            dict_wr_addr  = cmd_ff.new_code;
            dict_wr_data  = make_entry(prev_ent_ff, prev_code_ff, prev_first_ff,
                                       dict_q_ff.first_byte);
            dict_wr_en    = cmd_ff.add;
            prev_code_in  = cmd_ff.code;
            prev_first_in = dict_q_ff.first_byte;
            prev_ent_in   = dict_q_ff;
            prev_ent_in.length = walk_len;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            // one chain entry per cycle, next read issued from this data
            stk_wr_en = 1'b1;
            k_in      = k_ff - lzwd_pkg::LEN_W'(1);
            cur_in    = dict_q_ff.prefix;
            if (k_ff == lzwd_pkg::LEN_W'(1)) begin
               state_in = ST_GATHER;
            end else if (is_literal(dict_q_ff.prefix)) begin
               state_in = ST_LIT;
            end else begin
               dict_rd_en   = 1'b1;
               dict_rd_addr = dict_q_ff.prefix;
            end
         end
         ST_LIT: begin
            stk_wr_en   = 1'b1;
            stk_wr_data = cur_ff[7:0];
            state_in    = ST_GATHER;
         end
         ST_GATHER: begin
            if (pend_ff) begin
               asm_in[cap_ff[1:0]] = stack_q_ff;
               cap_in = cap_ff + 3'd1;
            end
            if (iss_ff < grp) begin
               stk_rd_en = 1'b1;
               iss_in    = iss_ff + 3'd1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (cap_ff + 3'd1 == grp)) begin
               pend_in  = 1'b0;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = asm_ff;
               rsp_count_in  = grp;
               rsp_last_in   = base_next == {1'b0, total_ff};
               rsp_status_in = lzwd_pkg::STATUS_DATA;
               base_in       = base_next[lzwd_pkg::LEN_W-1:0];
               iss_in        = '0;
               cap_in        = '0;
               asm_in        = '{default: 8'd0};
               state_in      = (base_next == {1'b0, total_ff}) ? ST_IDLE : ST_GATHER;
            end
         end
         ST_FLAG: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '{default: 8'd0};
               rsp_count_in  = 3'd0;
               rsp_last_in   = 1'b1;
               rsp_status_in = (cmd_ff.kind == lzwd_pkg::KIND_BAD) ?
                               lzwd_pkg::STATUS_BAD : lzwd_pkg::STATUS_END;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dict_wr_en) begin
         dict_mem[dict_wr_addr] <= dict_wr_data;
      end
      if (dict_rd_en) begin
         dict_q_ff <= dict_mem[dict_rd_addr];
      end
      if (stk_wr_en) begin
         stack_mem[stk_wr_addr] <= stk_wr_data;
      end
      if (stk_rd_en) begin
         stack_q_ff <= stack_mem[stk_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      total_ff      <= total_in;
      base_ff       <= base_in;
      iss_ff        <= iss_in;
      cap_ff        <= cap_in;
      asm_ff        <= asm_in;
      prev_code_ff  <= prev_code_in;
      prev_first_ff <= prev_first_in;
      prev_ent_ff   <= prev_ent_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/lzw_decoder_9_to_12_bit.sv]
// LZW decoder with 9- to 12-bit codes: top level.
// Depends on lzwd_pkg, lzwd_channels, lzwd_front, lzwd_code_fifo, lzwd_back.
//
// Usage: compressed bytes enter on req_if (valid/ready), one per transfer,
// with stream_end on the last byte of a stream. Decoded bytes leave on
// rsp_if, up to four per transfer, with byte_count, last_of_code on the
// final result of a code, and status (data, end code, bad first code).
// The front end unpacks and classifies codes in the cycle a byte arrives;
// a two-entry queue lets it take bytes while the expander is busy.
// The expander writes a literal straight to the reverse stack and walks a
// string one dictionary entry per cycle from a single-port read of the
// 4096-entry dictionary, then reads the string back from the reverse
// stack as results of up to four bytes each.
// Reset clears the control state at once; the dictionary needs no clearing
// since an entry is written before it is read. When rsp_if stalls, the
// result is held, the expander waits, and req_if.ready drops once the queue
// fills.
module lzw_decoder_9_to_12_bit (
   input  logic       clock,
   input  logic       reset,
   lzwd_req_if.sink   req_if,
   lzwd_rsp_if.source rsp_if
);

   logic              front_valid, front_ready;
   lzwd_pkg::cmd_type front_data;
   logic              back_valid, back_ready;
   lzwd_pkg::cmd_type back_data;

   lzwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd_data  (front_data),
      .cmd_ready (front_ready)
   );

   lzwd_code_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_data),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_data   (back_data),
      .pop_ready  (back_ready)
   );

   lzwd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_data  (back_data),
      .cmd_ready (back_ready),
      .rsp_if    (rsp_if)
   );

endmodule

[test/tb_lzwd_channels.sv]
// Note: the channel interfaces come from the RTL file hdl/lzwd_channels.sv.
// This file only adds the timescale for the testbench side; it declares nothing.
`timescale 1ns / 1ps

[test/tb_top.sv]
// Testbench for lzw_decoder_9_to_12_bit: drives compressed byte streams and
// checks every decoded result against a built-in LZW predictor.
// Depends on lzwd_pkg and lzwd_channels from the RTL.
`timescale 1ns / 1ps
module tb_top;

   typedef struct packed {
      logic [7:0] b0, b1, b2, b3;
      logic [2:0] cnt;
      logic       last;
      logic [1:0] status;
   } result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } byte_item_type;

   logic clock = 0;
   logic reset = 1;

   lzwd_req_if req_if ();
   lzwd_rsp_if rsp_if ();

   lzw_decoder_9_to_12_bit u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [19:0] p_store;
   int unsigned p_held, p_width, p_next, p_prev, p_prev_first, p_phase;
   logic [11:0] d_prefix [lzwd_pkg::DICT_DEPTH];
   logic [7:0]  d_last   [lzwd_pkg::DICT_DEPTH];
   logic [7:0]  d_first  [lzwd_pkg::DICT_DEPTH];
   int unsigned d_len    [lzwd_pkg::DICT_DEPTH];
   logic [7:0]  str_buf  [lzwd_pkg::MAX_STRING];

   result_type     expected_results[$];
   byte_item_type  pending_bytes[$];
   int             errors = 0;
   int             mismatches = 0;
   bit             hold_sender = 0;

   function automatic void restart_predictor();
      p_store = 0; p_held = 0; p_width = lzwd_pkg::MIN_WIDTH; p_next = lzwd_pkg::LIT_COUNT;
      p_prev = 0; p_prev_first = 0; p_phase = 0;
   endfunction

   function automatic int unsigned string_length(int unsigned c);
      int unsigned n;
      if (c < lzwd_pkg::LIT_COUNT) return 1;
      n = d_len[c];
      if (n < 1) n = 1;
      if (n > lzwd_pkg::MAX_STRING - 1) n = lzwd_pkg::MAX_STRING - 1;
      return n;
   endfunction

   function automatic logic [7:0] first_byte_of(int unsigned c);
      return c < lzwd_pkg::LIT_COUNT ? c[7:0] : d_first[c];
   endfunction

   function automatic int unsigned unwind_string(int unsigned c);
      int unsigned n, k;
      n = string_length(c);
      for (k = n; k > 0; k--) begin
         if (c < lzwd_pkg::LIT_COUNT) begin
            str_buf[k-1] = c[7:0];
            break;
         end
         str_buf[k-1] = d_last[c];
         c = d_prefix[c];
      end
      return n;
   endfunction

   function automatic bit grow_dictionary(logic [7:0] f);
      int unsigned n;
      n = p_next;
      if (n >= lzwd_pkg::DICT_DEPTH) return 0;
      if (string_length(p_prev) >= lzwd_pkg::MAX_STRING - 1) begin
         d_prefix[n] = d_prefix[p_prev];
         d_last[n]   = d_last[p_prev];
         d_first[n]  = d_first[p_prev];
         d_len[n]    = lzwd_pkg::MAX_STRING - 1;
      end else begin
         d_prefix[n] = 12'(p_prev);
         d_last[n]   = f;
         d_first[n]  = 8'(p_prev_first);
         d_len[n]    = string_length(p_prev) + 1;
      end
      p_next = n + 1;
      if (p_next >= (1 << p_width) && p_width < lzwd_pkg::MAX_WIDTH) p_width++;
      return 1;
   endfunction

   function automatic void push_flag(logic [1:0] st);
      result_type r;
      r = '0;
      r.last = 1;
      r.status = st;
      expected_results.push_back(r);
   endfunction

   function automatic void push_string(int unsigned n);
      result_type r;
      int unsigned i, cnt;
      logic [7:0] bb[4];
      i = 0;
      while (i < n) begin
         cnt = (n - i) < 4 ? n - i : 4;
         for (int j = 0; j < 4; j++) bb[j] = (j < cnt) ? str_buf[i+j] : 8'd0;
         r = '0;
         r.b0 = bb[0]; r.b1 = bb[1]; r.b2 = bb[2]; r.b3 = bb[3];
         r.cnt = 3'(cnt);
         i += cnt;
         r.last = (i >= n);
         r.status = lzwd_pkg::STATUS_DATA;
         expected_results.push_back(r);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] data, logic eos);
      int unsigned sh, code, n, newc;
      if (p_phase < 2) begin
         p_store = {p_store[11:0], data};
         p_held += 8;
         if (p_held >= p_width) begin
            sh = p_held - p_width;
            code = (p_store >> sh) & ((1 << p_width) - 1);
            p_held = sh;
            p_store &= (20'd1 << p_held) - 1;
            if (p_phase == 0) begin
               if (code >= lzwd_pkg::LIT_COUNT) begin
                  push_flag(lzwd_pkg::STATUS_BAD);
                  p_phase = 2;
               end else begin
                  p_prev = code; p_prev_first = code; p_phase = 1;
                  str_buf[0] = code[7:0];
                  push_string(1);
               end
            end else if (code == lzwd_pkg::END_CODE) begin
               push_flag(lzwd_pkg::STATUS_END);
               p_phase = 2;
            end else if (code < p_next) begin
               n = unwind_string(code);
               void'(grow_dictionary(first_byte_of(code)));
               p_prev = code;
               p_prev_first = first_byte_of(code);
               push_string(n);
            end else begin
               n = unwind_string(p_prev);
               newc = p_next;
               if (n < lzwd_pkg::MAX_STRING - 1) begin
                  str_buf[n] = 8'(p_prev_first);
                  n++;
               end
               if (grow_dictionary(8'(p_prev_first))) p_prev = newc;
               push_string(n);
            end
         end
      end
      if (eos) restart_predictor();
   endfunction

   // encoder-side bit packer for building well-formed streams
   logic [31:0] pack_acc;
   int          pack_bits;

   task automatic pack_code(int unsigned code, int unsigned w);
      pack_acc = (pack_acc << w) | (code & ((32'd1 << w) - 1));
      pack_bits += w;
      while (pack_bits >= 8) begin
         pending_bytes.push_back('{data: 8'(pack_acc >> (pack_bits - 8)), eos: 1'b0});
         pack_bits -= 8;
         pack_acc &= (32'd1 << pack_bits) - 1;
      end
   endtask

   // Build a stream of codes that tracks the decoder's dictionary size.
   task automatic build_stream(int ncodes, int mode);
      int unsigned nxt, w, c;
      pack_acc = 0; pack_bits = 0; nxt = lzwd_pkg::LIT_COUNT; w = lzwd_pkg::MIN_WIDTH;
      pack_code(mode == 1 ? 300 : $urandom_range(0, 255), w);
      if (mode != 1) begin
         for (int i = 1; i < ncodes; i++) begin
            case ($urandom_range(0, 5))
               0, 1:    c = $urandom_range(0, 255);
               2:       c = nxt;   // not yet defined: KwKwK
               default: c = (nxt > lzwd_pkg::LIT_COUNT) ?
                            $urandom_range(lzwd_pkg::LIT_COUNT, nxt - 1) :
                            $urandom_range(0, 255);
            endcase
            pack_code(c, w);
            if (nxt < lzwd_pkg::DICT_DEPTH) nxt++;
            if (nxt >= (1 << w) && w < lzwd_pkg::MAX_WIDTH) w++;
         end
         if (mode == 2) pack_code(lzwd_pkg::END_CODE, w);
      end
      // flush leftovers and a trailing stream-end byte
      if (pack_bits > 0) pack_code(0, 8 - pack_bits);
      pending_bytes.push_back('{data: 8'($urandom_range(0, 255)), eos: 1'b1});
   endtask

   // driver
   int gap_left = 0, burst_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
         req_if.in_byte <= 0;
         req_if.stream_end <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            decode_byte(req_if.in_byte, req_if.stream_end);
            void'(pending_bytes.pop_front());
         end
         if (req_if.valid && !req_if.ready) begin
            // hold the offered transfer
         end else if (hold_sender || pending_bytes.size() == 0) begin
            req_if.valid <= 0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 0;
         end else begin
            req_if.in_byte <= pending_bytes[0].data;
            req_if.stream_end <= pending_bytes[0].eos;
            req_if.valid <= 1;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end
         end
      end
   end

   // monitor and stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_if.ready <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.out_byte0, rsp_if.out_byte1, rsp_if.out_byte2,
                    rsp_if.out_byte3, rsp_if.byte_count, rsp_if.last_of_code,
                    rsp_if.status};
            if (expected_results.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected result %h", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: expected %h actual %h", want, got);
               end
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         rsp_if.ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      int wait_cycles;
      restart_predictor();
      repeat (7) @(posedge clock);
      reset <= 0;
      // directed: literal extremes, bad first code, known and undefined codes
      build_stream(1, 1);
      pack_acc = 0; pack_bits = 0;
      pack_code(0, 9); pack_code(255, 9); pack_code(256, 9); pack_code(258, 9);
      pack_code(0, 1);
      pending_bytes.push_back('{data: 8'hff, eos: 1'b1});
      build_stream(12, 2);
      while (pending_bytes.size() > 0) @(posedge clock);
      hold_sender = 1;
      while (expected_results.size() > 0) @(posedge clock);
      hold_sender = 0;
      // random: mostly well-formed streams, some raw noise
      for (int s = 0; s < 18; s++) begin
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 10; i++)
               pending_bytes.push_back('{data: 8'($urandom_range(0, 255)),
                                         eos: (i == 9)});
         end else begin
            build_stream($urandom_range(5, 25), $urandom_range(0, 6) == 0 ? 2 : 0);
         end
      end
      while (pending_bytes.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 600) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (errors == 0 && expected_results.size() == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
